>>> rtl/core/b31enc_pkg.sv
// ----------------------------------------------------------------------------
// Base-31 number encoder package
// Shared widths, character constants and the digit arithmetic helpers that
// the base-31 encoder stages use.
// ----------------------------------------------------------------------------
package b31enc_pkg;

   localparam int VALUE_WIDTH_DEF = 32;
   localparam int DIGIT_WIDTH     = 5;
   localparam int CHAR_WIDTH      = 7;
   localparam int SUM_WIDTH       = 10;

   // log2(31) scaled by 10000, used to size the digit count at elaboration.
   localparam int Log2BaseX10k = 49542;

   typedef logic [DIGIT_WIDTH-1:0] digit_type;
   typedef logic [CHAR_WIDTH-1:0]  char_type;
   typedef logic [SUM_WIDTH-1:0]   sum_type;

   localparam char_type CHAR_ZERO    = 7'd48;   // '0'
   localparam char_type CHAR_UPPER_A = 7'd65;   // 'A'
   localparam char_type CHAR_UPPER_V = 7'd86;   // 'V'
   localparam char_type CHAR_LOWER_A = 7'd97;   // 'a'

   localparam digit_type DECIMAL_COUNT  = 5'd10;
   localparam digit_type UPPER_CONT_CNT = 5'd5;

   // Since 32 is 1 modulo 31, a sum of base-32 chunks folds to the same residue.
   function automatic digit_type mod31(input sum_type s);
      logic [5:0] t;
      t = {1'b0, s[9:5]} + {1'b0, s[4:0]};
      if (t >= 6'd62) begin
         return DIGIT_WIDTH'(t - 6'd62);
      end else if (t >= 6'd31) begin
         return DIGIT_WIDTH'(t - 6'd31);
      end else begin
         return DIGIT_WIDTH'(t);
      end
   endfunction

   // Quotient of (rem * 32 + chunk) / 31 for rem below 31, as ((n + 1) * 33) >> 10.
   function automatic digit_type div31_step(input digit_type rem, input digit_type chunk);
      logic [10:0] m;
      logic [15:0] p;
      m = {1'b0, rem, chunk} + 11'd1;
      p = {m, 5'b0} + 16'(m);
      return p[14:10];
   endfunction

   function automatic char_type terminal_char(input digit_type d);
      if (d < DECIMAL_COUNT) begin
         return CHAR_ZERO + CHAR_WIDTH'(d);
      end else begin
         return CHAR_UPPER_A + CHAR_WIDTH'(d - DECIMAL_COUNT);
      end
   endfunction

   function automatic char_type continue_char(input digit_type d);
      if (d < UPPER_CONT_CNT) begin
         return CHAR_UPPER_V + CHAR_WIDTH'(d);
      end else begin
         return CHAR_LOWER_A + CHAR_WIDTH'(d - UPPER_CONT_CNT);
      end
   endfunction

endpackage

>>> rtl/core/b31enc_req_if.sv
// ----------------------------------------------------------------------------
// Base-31 encoder request channel
// Valid/ready channel that carries one unsigned number per item.
// ----------------------------------------------------------------------------
interface b31enc_req_if import b31enc_pkg::*; #(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
);
   logic                   valid;
   logic                   ready;
   logic [VALUE_WIDTH-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

>>> rtl/core/b31enc_rsp_if.sv
// ----------------------------------------------------------------------------
// Base-31 encoder response channel
// Valid/ready channel that carries one encoded character per item.
// ----------------------------------------------------------------------------
interface b31enc_rsp_if import b31enc_pkg::*;;
   logic     valid;
   logic     ready;
   char_type character;
   logic     last;

   modport source (output valid, output character, output last, input ready);
   modport sink   (input valid, input character, input last, output ready);
endinterface

>>> rtl/core/b31enc_digit_stage.sv
// ----------------------------------------------------------------------------
// Base-31 digit stage
// One pipeline stage: divides its value by 31, records the remainder as digit
// STAGE_INDEX and registers the quotient for the next stage.
// ----------------------------------------------------------------------------
module b31enc_digit_stage import b31enc_pkg::*; #(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
   parameter int NUM_DIGITS  = 7,
   parameter int STAGE_INDEX = 0
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              up_valid,
   output logic                              up_ready,
   input  logic [VALUE_WIDTH-1:0]            up_value,
   input  logic [NUM_DIGITS-1:0][DIGIT_WIDTH-1:0] up_digits,
   output logic                              dn_valid,
   input  logic                              dn_ready,
   output logic [VALUE_WIDTH-1:0]            dn_value,
   output logic [NUM_DIGITS-1:0][DIGIT_WIDTH-1:0] dn_digits
);

   localparam int NUM_CHUNKS = (VALUE_WIDTH + DIGIT_WIDTH - 1) / DIGIT_WIDTH;
   localparam int PAD_WIDTH  = NUM_CHUNKS * DIGIT_WIDTH;

   logic [PAD_WIDTH-1:0] padded;
   logic [PAD_WIDTH-1:0] quotient;
   sum_type              prefix_sum [NUM_CHUNKS];
   sum_type              total_sum;

   logic                                   valid_ff, valid_in;
   logic [VALUE_WIDTH-1:0]                 value_ff, value_in;
   logic [NUM_DIGITS-1:0][DIGIT_WIDTH-1:0] digits_ff, digits_in;

   // Long division in base 32. The remainder ahead of each chunk is the sum of
   // the chunks above it folded modulo 31, so every chunk works independently.
   always_comb begin
      padded    = PAD_WIDTH'(up_value);
      total_sum = '0;
      for (int i = 0; i < NUM_CHUNKS; i++) begin
         total_sum = total_sum + SUM_WIDTH'(padded[i*DIGIT_WIDTH +: DIGIT_WIDTH]);
      end
      for (int i = 0; i < NUM_CHUNKS; i++) begin
         prefix_sum[i] = '0;
         for (int j = i + 1; j < NUM_CHUNKS; j++) begin
            prefix_sum[i] = prefix_sum[i] + SUM_WIDTH'(padded[j*DIGIT_WIDTH +: DIGIT_WIDTH]);
         end
         quotient[i*DIGIT_WIDTH +: DIGIT_WIDTH] =
            div31_step(mod31(prefix_sum[i]), padded[i*DIGIT_WIDTH +: DIGIT_WIDTH]);
      end
   end

   always_comb begin
      digits_in              = up_digits;
      digits_in[STAGE_INDEX] = mod31(total_sum);
      value_in               = quotient[VALUE_WIDTH-1:0];
   end

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         value_ff  <= value_in;
         digits_ff <= digits_in;
      end
   end

   assign dn_valid  = valid_ff;
   assign dn_value  = value_ff;
   assign dn_digits = digits_ff;

endmodule

>>> rtl/core/b31enc_serializer.sv
// ----------------------------------------------------------------------------
// Base-31 character serializer
// Holds one item's digits and sends them as characters, most significant
// digit first, the least significant one marked last.
// ----------------------------------------------------------------------------
module b31enc_serializer import b31enc_pkg::*; #(
   parameter int NUM_DIGITS = 7
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   up_valid,
   output logic                                   up_ready,
   input  logic [NUM_DIGITS-1:0][DIGIT_WIDTH-1:0] up_digits,
   b31enc_rsp_if.source                           rsp_bus
);

   localparam int IDX_WIDTH = $clog2(NUM_DIGITS);

   logic                                   busy_ff, busy_in;
   logic [IDX_WIDTH-1:0]                   index_ff, index_in;
   logic [NUM_DIGITS-1:0][DIGIT_WIDTH-1:0] digits_ff;
   logic [IDX_WIDTH-1:0]                   top_index;
   logic                                   out_take;
   logic                                   finishing;
   logic                                   load;
   digit_type                              cur_digit;

   // Highest nonzero digit; a zero value still sends its single digit.
   always_comb begin
      top_index = '0;
      for (int i = 1; i < NUM_DIGITS; i++) begin
         if (up_digits[i] != '0) begin
            top_index = IDX_WIDTH'(i);
         end
      end
   end

   assign out_take  = busy_ff && rsp_bus.ready;
   assign finishing = out_take && (index_ff == '0);
   assign up_ready  = !busy_ff || finishing;
   assign load      = up_ready && up_valid;
   assign busy_in   = up_ready ? up_valid : busy_ff;

   always_comb begin
      if (load) begin
         index_in = top_index;
      end else if (out_take) begin
         index_in = index_ff - 1'b1;
      end else begin
         index_in = index_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         index_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         index_ff <= index_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         digits_ff <= up_digits;
      end
   end

   assign cur_digit         = digits_ff[index_ff];
   assign rsp_bus.valid     = busy_ff;
   assign rsp_bus.last      = (index_ff == '0);
   assign rsp_bus.character = (index_ff == '0) ? terminal_char(cur_digit)
                                               : continue_char(cur_digit);

endmodule

>>> rtl/core/base31_varlen_number_encoder_core.sv
// ----------------------------------------------------------------------------
// Base-31 variable-length number encoder
// Encodes an unsigned number as a self-terminating string of base-31 digit
// characters, most significant digit first.
//
//   Channel   Direction  Item                         Payload
//   req_bus   in         one number                   value
//   rsp_bus   out        one character of the code    character, last
//
// The number passes through one divide-by-31 stage per digit (7 stages at 32
// bits), then a serializer. Each item sends as many characters as it has
// digits (1 to 7 at 32 bits), one character per cycle unless rsp_bus stalls.
// Reset clears the stage valid bits and the serializer. When rsp_bus stalls,
// the stages keep filling until full, then req_bus.ready drops.
// ----------------------------------------------------------------------------
module base31_varlen_number_encoder_core import b31enc_pkg::*; #(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   b31enc_req_if.sink   req_bus,
   b31enc_rsp_if.source rsp_bus
);

   localparam int NUM_DIGITS = (VALUE_WIDTH * 10000 + Log2BaseX10k - 1) / Log2BaseX10k;

   logic                                   st_valid  [NUM_DIGITS];
   logic                                   st_ready  [NUM_DIGITS];
   logic [VALUE_WIDTH-1:0]                 st_value  [NUM_DIGITS];
   logic [NUM_DIGITS-1:0][DIGIT_WIDTH-1:0] st_digits [NUM_DIGITS];
   logic                                   dn_valid  [NUM_DIGITS];
   logic                                   dn_ready  [NUM_DIGITS];
   logic [NUM_DIGITS-1:0][DIGIT_WIDTH-1:0] dn_digits [NUM_DIGITS];
   logic                                   ser_ready;

   assign st_valid[0]  = req_bus.valid;
   assign st_value[0]  = req_bus.value;
   assign st_digits[0] = '0;
   assign req_bus.ready = st_ready[0];

   for (genvar k = 0; k < NUM_DIGITS; k++) begin : g_stage
      if (k < NUM_DIGITS - 1) begin : g_mid
         assign st_valid[k+1]  = dn_valid[k];
         assign st_digits[k+1] = dn_digits[k];
         assign dn_ready[k]    = st_ready[k+1];

         b31enc_digit_stage #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .NUM_DIGITS  (NUM_DIGITS),
            .STAGE_INDEX (k)
         ) u_stage (
            .clock     (clock),
            .reset     (reset),
            .up_valid  (st_valid[k]),
            .up_ready  (st_ready[k]),
            .up_value  (st_value[k]),
            .up_digits (st_digits[k]),
            .dn_valid  (dn_valid[k]),
            .dn_ready  (dn_ready[k]),
            .dn_value  (st_value[k+1]),
            .dn_digits (dn_digits[k])
         );
      end else begin : g_last
         // The quotient after the top digit is always zero and goes nowhere.
         assign dn_ready[k] = ser_ready;

         b31enc_digit_stage #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .NUM_DIGITS  (NUM_DIGITS),
            .STAGE_INDEX (k)
         ) u_stage (
            .clock     (clock),
            .reset     (reset),
            .up_valid  (st_valid[k]),
            .up_ready  (st_ready[k]),
            .up_value  (st_value[k]),
            .up_digits (st_digits[k]),
            .dn_valid  (dn_valid[k]),
            .dn_ready  (dn_ready[k]),
            .dn_value  (),
            .dn_digits (dn_digits[k])
         );
      end
   end

   b31enc_serializer #(
      .NUM_DIGITS (NUM_DIGITS)
   ) u_serializer (
      .clock     (clock),
      .reset     (reset),
      .up_valid  (dn_valid[NUM_DIGITS-1]),
      .up_ready  (ser_ready),
      .up_digits (dn_digits[NUM_DIGITS-1]),
      .rsp_bus   (rsp_bus)
   );

endmodule
